// ===== rtl/core/vev_pkg.sv =====
// Package for the velocity/energy vector block: field widths, accumulator
// widths, the frame-sum record passed from front to back, and divider codes.
// No dependencies.
package vev_pkg;

  // Field and accumulator widths
  localparam int GainW = 16;
  localparam int AbsW  = 22;
  localparam int VelW  = 38;
  localparam int SqrW  = 37;
  localparam int EneW  = 53;

  // Divider: 16 quotient bits, one per step; the top bit flags saturation
  localparam int QuoW  = 16;
  localparam int DivW  = EneW;
  localparam int StepW = $clog2(QuoW);

  // Frame queue between front and back
  localparam int FifoDepth = 2;
  localparam int FifoAw    = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = FifoAw + 1;

  localparam logic signed [QuoW-1:0] Q15Max = {1'b0, {(QuoW-1){1'b1}}};
  localparam logic signed [QuoW-1:0] Q15Min = {1'b1, {(QuoW-1){1'b0}}};

  // Quotient order in the back end
  typedef enum logic [1:0] {
    OP_VEL_X,
    OP_VEL_Y,
    OP_ENE_X,
    OP_ENE_Y
  } vev_op_e;

  localparam int NumOps = 4;

  // Frame sums handed from the accumulator to the divider
  typedef struct packed {
    logic        [AbsW-1:0] abs_sum;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic        [SqrW-1:0] sqr_sum;
    logic signed [EneW-1:0] ene_x;
    logic signed [EneW-1:0] ene_y;
  } vev_sums_t;

endpackage

// ===== rtl/core/vev_if.sv =====
// Valid/ready channel interfaces for the velocity/energy vector block:
// one for channel beats in, one for vector beats out. Depends on vev_pkg.

interface vev_in_if import vev_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GainW-1:0]  gain;
  logic signed [GainW-1:0]  speaker_x;
  logic signed [GainW-1:0]  speaker_y;
  logic                     last_channel;

  modport source (output valid, gain, speaker_x, speaker_y, last_channel, input ready);
  modport sink   (input valid, gain, speaker_x, speaker_y, last_channel, output ready);
endinterface

interface vev_out_if import vev_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [QuoW-1:0]  velocity_x;
  logic signed [QuoW-1:0]  velocity_y;
  logic signed [QuoW-1:0]  energy_x;
  logic signed [QuoW-1:0]  energy_y;

  modport source (output valid, velocity_x, velocity_y, energy_x, energy_y, input ready);
  modport sink   (input valid, velocity_x, velocity_y, energy_x, energy_y, output ready);
endinterface

// ===== rtl/core/vev_front.sv =====
// Front end: takes channel beats, forms the gain products in the S_MUL and
// S_ACC states and accumulates the six frame sums; pushes them on the last
// channel. Depends on vev_pkg and vev_in_if.
module vev_front import vev_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vev_in_if.sink     in_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output vev_sums_t  q_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ENE,
    S_PUSH
  } state_e;

  state_e    state_q;
  vev_sums_t sums_q;

  logic signed [GainW-1:0]   g_q, x_q, y_q;
  logic                      last_q;
  logic signed [2*GainW-1:0] gx_q, gy_q;
  logic [2*GainW-2:0]        g2_q;
  logic [GainW:0]            absg_q;
  logic signed [3*GainW-2:0] g2x_q, g2y_q;

  logic signed [2*GainW-1:0] gx_d, gy_d, gg_d;
  logic signed [GainW:0]     gext;
  logic [GainW:0]            absg_d;
  logic signed [3*GainW-2:0] g2x_d, g2y_d;

  assign in_i.ready = (state_q == S_IDLE);
  assign q_push_o   = (state_q == S_PUSH) && !q_full_i;
  assign q_data_o   = sums_q;

  // Products of the held channel
  always_comb begin
    gx_d   = g_q * x_q;
    gy_d   = g_q * y_q;
    gg_d   = g_q * g_q;
    gext   = (GainW+1)'(g_q);
    absg_d = gext[GainW] ? (GainW+1)'(-gext) : (GainW+1)'(gext);
    g2x_d  = $signed({1'b0, g2_q}) * x_q;
    g2y_d  = $signed({1'b0, g2_q}) * y_q;
  end

  // Sequence one channel and keep the frame sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sums_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          sums_q.abs_sum <= sums_q.abs_sum + AbsW'(absg_q);
          sums_q.vel_x   <= $signed(sums_q.vel_x) + VelW'(gx_q);
          sums_q.vel_y   <= $signed(sums_q.vel_y) + VelW'(gy_q);
          sums_q.sqr_sum <= sums_q.sqr_sum + SqrW'(g2_q);
          state_q        <= S_ENE;
        end
        S_ENE: begin
          sums_q.ene_x <= $signed(sums_q.ene_x) + EneW'(g2x_q);
          sums_q.ene_y <= $signed(sums_q.ene_y) + EneW'(g2y_q);
          state_q      <= last_q ? S_PUSH : S_IDLE;
        end
        S_PUSH: begin
          // hand the frame over, then start the next one from zero
          if (!q_full_i) begin
            sums_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Hold the beat and its products
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      g_q    <= in_i.gain;
      x_q    <= in_i.speaker_x;
      y_q    <= in_i.speaker_y;
      last_q <= in_i.last_channel;
    end
    if (state_q == S_MUL) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      g2_q   <= gg_d[2*GainW-2:0];
      absg_q <= absg_d;
    end
    if (state_q == S_ACC) begin
      g2x_q <= g2x_d;
      g2y_q <= g2y_d;
    end
  end

endmodule

// ===== rtl/core/vev_fifo.sv =====
// Short queue of frame sums between the accumulator and the divider.
// Depends on vev_pkg.
module vev_fifo import vev_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vev_sums_t  push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output vev_sums_t  head_o
);

  vev_sums_t          mem_q [FifoDepth];
  logic [FifoAw-1:0]  wptr_q, rptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/vev_div.sv =====
// Back end: one restoring divider, one quotient bit a cycle, run four times
// per frame; saturates to Q1.15 and holds the result beat. Depends on
// vev_pkg and vev_out_if.
module vev_div import vev_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  vev_sums_t  q_data_i,
  output logic       q_pop_o,
  vev_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_STEP,
    S_FIN,
    S_SEND
  } state_e;

  state_e              state_q;
  vev_op_e             op_q;
  logic [StepW-1:0]    step_q;
  logic                out_valid_q;
  logic                send_ok;

  logic [DivW-1:0]     rem_q, dvs_q;
  logic [QuoW-1:0]     quo_q;
  logic                neg_q, zero_q;
  logic signed [QuoW-1:0] res_q [NumOps];
  logic signed [QuoW-1:0] vx_q, vy_q, ex_q, ey_q;

  logic signed [DivW-1:0] num;
  logic [DivW-1:0]     den, mag;
  logic [DivW:0]       diff;
  logic                ge;
  logic signed [QuoW-1:0] res_d;

  assign send_ok        = !out_valid_q || out_o.ready;
  assign q_pop_o        = (state_q == S_SEND) && send_ok;
  assign out_o.valid    = out_valid_q;
  assign out_o.velocity_x = vx_q;
  assign out_o.velocity_y = vy_q;
  assign out_o.energy_x   = ex_q;
  assign out_o.energy_y   = ey_q;

  // Pick operands for the current quotient and take the magnitude
  always_comb begin
    unique case (op_q)
      OP_VEL_X: begin
        num = DivW'(q_data_i.vel_x);
        den = DivW'(q_data_i.abs_sum);
      end
      OP_VEL_Y: begin
        num = DivW'(q_data_i.vel_y);
        den = DivW'(q_data_i.abs_sum);
      end
      OP_ENE_X: begin
        num = DivW'(q_data_i.ene_x);
        den = DivW'(q_data_i.sqr_sum);
      end
      OP_ENE_Y: begin
        num = DivW'(q_data_i.ene_y);
        den = DivW'(q_data_i.sqr_sum);
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
    mag = num[DivW-1] ? DivW'(-num) : DivW'(num);
  end

  // Trial subtract
  assign diff = {1'b0, rem_q} - {1'b0, dvs_q};
  assign ge   = !diff[DivW];

  // Finish: zero denominator, saturation, sign
  always_comb begin
    if (zero_q) begin
      res_d = '0;
    end else if (quo_q[QuoW-1]) begin
      res_d = neg_q ? Q15Min : Q15Max;
    end else if (neg_q) begin
      res_d = QuoW'(-$signed(quo_q));
    end else begin
      res_d = $signed(quo_q);
    end
  end

  // Sequence the four divisions and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_VEL_X;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise the result beat on send, drop it once taken
      if (state_q == S_SEND && send_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            op_q    <= OP_VEL_X;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_q  <= StepW'(QuoW - 1);
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (step_q == '0) begin
            state_q <= S_FIN;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_FIN: begin
          if (op_q == OP_ENE_Y) begin
            state_q <= S_SEND;
          end else begin
            op_q    <= vev_op_e'(op_q + 2'd1);
            state_q <= S_LOAD;
          end
        end
        S_SEND: begin
          if (send_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Divider datapath and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      rem_q  <= mag;
      dvs_q  <= den << (QuoW - 1);
      neg_q  <= num[DivW-1];
      zero_q <= (den == '0);
      quo_q  <= '0;
    end
    if (state_q == S_STEP) begin
      if (ge) begin
        rem_q <= diff[DivW-1:0];
      end
      quo_q <= {quo_q[QuoW-2:0], ge};
      dvs_q <= dvs_q >> 1;
    end
    if (state_q == S_FIN) begin
      res_q[op_q] <= res_d;
    end
    if (state_q == S_SEND && send_ok) begin
      vx_q <= res_q[OP_VEL_X];
      vy_q <= res_q[OP_VEL_Y];
      ex_q <= res_q[OP_ENE_X];
      ey_q <= res_q[OP_ENE_Y];
    end
  end

endmodule

// ===== rtl/core/velocity_energy_vector.sv =====
// Top level of the velocity/energy vector block: accumulator front end,
// frame-sum queue and divider back end. Depends on vev_pkg, vev_if,
// vev_front, vev_fifo and vev_div.
//
//   channel  dir  beat contents
//   in_i     in   gain, speaker_x, speaker_y, last_channel (one loudspeaker)
//   out_o    out  velocity_x, velocity_y, energy_x, energy_y (one per frame)
//
// A channel passes the front-end states take, multiply, accumulate and
// energy accumulate, an order set by the two-step multiply of g*g by the
// speaker position; the last channel of a frame adds a push state to hand
// its sums to the queue. The divider makes one quotient bit per cycle, with
// a state to pick up a frame and one to send; the queue holds two frames,
// so the front end keeps taking channels while the divider runs, until the
// queue is full. The result register frees as soon as its beat is taken.
// Reset is asynchronous, active low, and clears all sums at once.
module velocity_energy_vector import vev_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vev_in_if.sink     in_i,
  vev_out_if.source  out_o
);

  logic      q_push, q_full, q_pop, q_empty;
  vev_sums_t q_wdata, q_head;

  vev_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  vev_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  vev_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for velocity_energy_vector: drives channel beats, predicts the
// velocity and energy vector of every frame and compares each result beat.
// Depends on vev_pkg, vev_if and the velocity_energy_vector RTL.
module tb_top import vev_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned MaxFrame    = 64;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  typedef struct packed {
    logic signed [QuoW-1:0] vel_x;
    logic signed [QuoW-1:0] vel_y;
    logic signed [QuoW-1:0] ene_x;
    logic signed [QuoW-1:0] ene_y;
  } vectors_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vev_in_if  in_if ();
  vev_out_if out_if ();

  velocity_energy_vector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Frame sums as the block should hold them
  logic [AbsW-1:0] abs_acc;
  logic [VelW-1:0] vx_acc;
  logic [VelW-1:0] vy_acc;
  logic [SqrW-1:0] sq_acc;
  logic [EneW-1:0] ex_acc;
  logic [EneW-1:0] ey_acc;

  vectors_t    frame_vectors_q[$];
  int unsigned mismatch_count = 0;

  // Sender burst state and receiver controls
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          allow_gaps = 1'b1;
  sink_mode_e  sink_mode  = SINK_ALWAYS;
  int unsigned hold_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Truncating divide of a signed w-bit sum by an unsigned sum, saturated to Q1.15
  function automatic logic signed [QuoW-1:0] q15_quot(logic [63:0] num, int unsigned w,
                                                      logic [63:0] den);
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    if (den == 64'd0) return '0;
    m   = (64'd1 << w) - 64'd1;
    num = num & m;
    neg = num[w-1];
    mag = neg ? ((~num + 64'd1) & m) : num;
    q   = mag / den;
    if (neg) begin
      if (q > 64'd32768) q = 64'd32768;
      return QuoW'(64'h10000 - q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return QuoW'(q);
  endfunction

  function automatic void clear_sums();
    abs_acc = '0;
    vx_acc  = '0;
    vy_acc  = '0;
    sq_acc  = '0;
    ex_acc  = '0;
    ey_acc  = '0;
  endfunction

  // Add one channel to the frame sums; on the last channel queue the vectors
  function automatic void add_channel(logic signed [GainW-1:0] g, logic signed [GainW-1:0] x,
                                      logic signed [GainW-1:0] y, logic last);
    longint   gl;
    longint   xl;
    longint   yl;
    longint   g2;
    vectors_t vec;
    gl = g;
    xl = x;
    yl = y;
    g2 = gl * gl;
    abs_acc = abs_acc + AbsW'(gl < 0 ? -gl : gl);
    vx_acc  = vx_acc + VelW'(gl * xl);
    vy_acc  = vy_acc + VelW'(gl * yl);
    sq_acc  = sq_acc + SqrW'(g2);
    ex_acc  = ex_acc + EneW'(g2 * xl);
    ey_acc  = ey_acc + EneW'(g2 * yl);
    if (last) begin
      vec.vel_x = q15_quot(vx_acc, VelW, abs_acc);
      vec.vel_y = q15_quot(vy_acc, VelW, abs_acc);
      vec.ene_x = q15_quot(ex_acc, EneW, sq_acc);
      vec.ene_y = q15_quot(ey_acc, EneW, sq_acc);
      frame_vectors_q.push_back(vec);
      clear_sums();
    end
  endfunction

  // Random Q1.15 value leaning on the extremes
  function automatic logic signed [GainW-1:0] pick_q15();
    case ($urandom_range(0, 9))
      0:       return Q15Min;
      1:       return Q15Max;
      2:       return '0;
      3:       return GainW'($urandom_range(0, 31)) - GainW'(16);
      default: return GainW'($urandom);
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic signed [QuoW-1:0] got,
                             input logic signed [QuoW-1:0] want);
    if (got !== want)
      report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  // Send one channel beat; the task is entered and left just after a rising edge
  task automatic send_channel(input logic signed [GainW-1:0] g,
                              input logic signed [GainW-1:0] x,
                              input logic signed [GainW-1:0] y, input logic last);
    if (gap_left > 0) begin
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    in_if.valid        <= 1'b1;
    in_if.gain         <= g;
    in_if.speaker_x    <= x;
    in_if.speaker_y    <= y;
    in_if.last_channel <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    add_channel(g, x, y, last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left   = allow_gaps ? $urandom_range(0, 6) : 0;
      if (gap_left > 0) in_if.valid <= 1'b0;
    end
  endtask

  // Drop valid, wait for every pending frame and let the divider settle
  task automatic finish_phase();
    if (gap_left == 0) in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_vectors_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One-channel frames at the field extremes, saturation both ways, zero gain
  task automatic test_single_channels();
    sink_mode  = SINK_ALWAYS;
    allow_gaps = 1'b1;
    send_channel(Q15Max, Q15Max, Q15Max, 1'b1);
    send_channel(Q15Min, Q15Min, Q15Min, 1'b1);
    send_channel(Q15Max, Q15Min, Q15Min, 1'b1);
    send_channel(Q15Min, Q15Max, Q15Min, 1'b1);
    send_channel(16'sd0, Q15Max, Q15Min, 1'b1);
    send_channel(16'sd1, -16'sd1, 16'sd1, 1'b1);
    send_channel(-16'sd1, Q15Max, Q15Min, 1'b1);
    finish_phase();
  endtask

  // Multi-channel frames: cancelling sums, all-zero gains, mixed signs
  task automatic test_short_frames();
    sink_mode = SINK_PATTERN;
    send_channel(16'sd1000, 16'sd20000, -16'sd5000, 1'b0);
    send_channel(-16'sd1000, 16'sd20000, -16'sd5000, 1'b1);
    send_channel(16'sd0, 16'sd12345, -16'sd321, 1'b0);
    send_channel(16'sd0, Q15Min, Q15Max, 1'b1);
    send_channel(16'sd0, 16'sd23170, 16'sd23170, 1'b0);
    send_channel(16'sd23170, 16'sd23170, -16'sd23170, 1'b0);
    send_channel(-16'sd11585, -16'sd23170, 16'sd23170, 1'b0);
    send_channel(16'sd0, 16'sd0, Q15Max, 1'b1);
    send_channel(Q15Min, Q15Min, Q15Max, 1'b0);
    send_channel(Q15Min, Q15Min, Q15Max, 1'b1);
    finish_phase();
  endtask

  // Frames past the accumulator widths: sums wrap, incl. wrapped-to-zero denominators
  task automatic test_long_frames();
    sink_mode = SINK_RANDOM;
    for (int i = 0; i < 128; i++) send_channel(Q15Min, Q15Min, Q15Max, i == 127);
    for (int i = 0; i < 136; i++) send_channel(Q15Min, Q15Min, pick_q15(), i == 135);
    finish_phase();
  endtask

  // Hold the result side off so the frame queue fills and the input stalls
  task automatic test_backpressure();
    sink_mode  = SINK_ALWAYS;
    allow_gaps = 1'b0;
    hold_left  = 600;
    for (int f = 0; f < 12; f++) begin
      send_channel(pick_q15(), pick_q15(), pick_q15(), 1'b0);
      send_channel(pick_q15(), pick_q15(), pick_q15(), 1'b1);
    end
    finish_phase();
    allow_gaps = 1'b1;
  endtask

  // Random frames, mostly short, sometimes up to the full channel count
  task automatic test_random_frames(input int unsigned n_items, input sink_mode_e mode,
                                    input bit gaps);
    int unsigned sent;
    int unsigned len;
    sink_mode  = mode;
    allow_gaps = gaps;
    sent       = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MaxFrame) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++)
        send_channel(pick_q15(), pick_q15(), pick_q15(), i == len - 1);
      sent += len;
    end
    finish_phase();
  endtask

  // Result side: long hold when asked, else the selected stall pattern
  initial begin
    int unsigned phase;
    phase = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_RANDOM:  out_if.ready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: out_if.ready <= ((phase % 7) > 1);
          default:      out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare every result beat with the oldest predicted frame
  always @(posedge clk_i) begin
    vectors_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (frame_vectors_q.size() == 0) begin
        report_error("result beat with no frame pending");
      end else begin
        want = frame_vectors_q.pop_front();
        check_field("velocity_x", out_if.velocity_x, want.vel_x);
        check_field("velocity_y", out_if.velocity_y, want.vel_y);
        check_field("energy_x", out_if.energy_x, want.ene_x);
        check_field("energy_y", out_if.energy_y, want.ene_y);
      end
    end
  end

  // Stop a hung run
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    in_if.valid        <= 1'b0;
    in_if.gain         <= '0;
    in_if.speaker_x    <= '0;
    in_if.speaker_y    <= '0;
    in_if.last_channel <= 1'b0;
    clear_sums();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_channels();
    test_short_frames();
    test_long_frames();
    test_backpressure();
    test_random_frames(65, SINK_ALWAYS, 1'b0);
    test_random_frames(65, SINK_RANDOM, 1'b1);
    test_random_frames(65, SINK_PATTERN, 1'b1);
    if (mismatch_count == 0 && frame_vectors_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vev_pkg.sv
rtl/core/vev_if.sv
rtl/core/vev_front.sv
rtl/core/vev_fifo.sv
rtl/core/vev_div.sv
rtl/core/velocity_energy_vector.sv
bench/tb_top.sv
